// File: design/type_signature_validator_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the type signature validator.
// All checks are clocked on clk and are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef TYPE_SIGNATURE_VALIDATOR_TOP_DEFINES_SVH
`define TYPE_SIGNATURE_VALIDATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tsv_pkg.sv
// ---------------------------------------------------------------------------
// tsv_pkg
// Shared constants, beat types and the type code table of the validator.
// ---------------------------------------------------------------------------
package tsv_pkg;

  localparam int MAX_NEST_DEPTH_DEF = 64;
  localparam logic [7:0] MAX_SIG_LEN = 8'd255;

  // Signature characters with a structural meaning.
  localparam logic [7:0] CH_ARRAY   = 8'h61; // 'a'
  localparam logic [7:0] CH_LPAREN  = 8'h28; // '('
  localparam logic [7:0] CH_RPAREN  = 8'h29; // ')'
  localparam logic [7:0] CH_LBRACE  = 8'h7b; // '{'
  localparam logic [7:0] CH_RBRACE  = 8'h7d; // '}'
  localparam logic [7:0] CH_VARIANT = 8'h76; // 'v'

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty_req;
  } tsv_in_t;

  typedef struct packed {
    logic done_res;
    logic valid_res;
    logic type_end;
  } tsv_out_t;

  // True for the basic type codes that may also serve as dict keys.
  function automatic logic is_basic(input logic [7:0] c);
    logic r;
    unique case (c)
      8'h79, 8'h62, 8'h6e, 8'h71, 8'h69, 8'h75, 8'h78,
      8'h74, 8'h68, 8'h64, 8'h73, 8'h6f, 8'h67: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: design/tsv_ifs.sv
// ---------------------------------------------------------------------------
// tsv_in_if / tsv_out_if
// Valid/ready channels carrying signature characters and verdict beats.
// ---------------------------------------------------------------------------
interface tsv_in_if;
  import tsv_pkg::*;
  logic    valid;
  logic    ready;
  tsv_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsv_out_if;
  import tsv_pkg::*;
  logic     valid;
  logic     ready;
  tsv_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/type_signature_validator_top.sv
// Flow: a character is registered in S_IDLE and checked in S_STEP. An opening
// character, a rejected or empty beat goes straight on to S_DONE; any other
// character passes through S_POP, where the nesting stack unit pops one array
// level per cycle for each array level that the character completes. S_DONE loads
// the verdict beat once the result register is free; a new character is taken only after that.
// Reset (rst, synchronous) clears the stack, the counters and mode to zero.
// ---------------------------------------------------------------------------
// type_signature_validator_top
// Streaming validator for typed-message type signatures, one character per
// input beat and one result beat per input beat.
// ---------------------------------------------------------------------------
`include "type_signature_validator_top_defines.svh"

module type_signature_validator_top #(
  parameter int MAX_NEST_DEPTH = tsv_pkg::MAX_NEST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  tsv_in_if.sink    chr,
  tsv_out_if.source verdict
);
  import tsv_pkg::*;

  // Depth counter holds 0..MAX_NEST_DEPTH, the struct counter 0..MAX/2.
  localparam int DW = $clog2(MAX_NEST_DEPTH + 1);
  localparam int SW = $clog2(MAX_NEST_DEPTH / 2 + 1);
  localparam int IW = (MAX_NEST_DEPTH > 1) ? $clog2(MAX_NEST_DEPTH) : 1;
  localparam logic [DW:0] MAX_V  = (DW + 1)'(MAX_NEST_DEPTH);
  localparam logic [DW:0] HALF_V = (DW + 1)'(MAX_NEST_DEPTH / 2);

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ARRAY  = 2'd1,
    KIND_STRUCT = 2'd2,
    KIND_DICT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_POP,
    S_DONE
  } state_t;

  state_t                    state;
  logic                      mode;
  logic [DW-1:0]             depth;
  logic [SW-1:0]             scount;
  logic [MAX_NEST_DEPTH-1:0] amask;
  logic [MAX_NEST_DEPTH-1:0] dmask;
  kind_t                     kind;
  logic [7:0]                prev1;
  logic [7:0]                prev2;
  logic [7:0]                ccount;
  logic                      failed;
  logic                      stc;     // a complete top-level type has closed
  logic                      ended;
  logic [7:0]                ch_q;
  logic                      last_q;
  logic                      empty_q;

  // Stack unit: the candidate depth and struct count for an opening
  // character, and the kind of the level below the current top.
  logic [DW:0]   nd;
  logic [DW:0]   nt;
  logic [DW-1:0] dec;
  logic [DW-1:0] dec2;
  logic [IW-1:0] top_idx;
  logic [IW-1:0] dec_idx;
  logic [IW-1:0] below_idx;
  kind_t         kind_dec;
  logic          open_ok;
  logic          dict_ok;
  logic          is_open;
  logic          is_close;
  logic          step_ok;
  logic          slot_free;

  assign nd        = {1'b0, depth} + (DW + 1)'(1);
  assign nt        = {{(DW + 1 - SW){1'b0}}, scount} + (DW + 1)'(ch_q != CH_ARRAY);
  assign dec       = depth - DW'(1);
  assign dec2      = depth - DW'(2);
  assign top_idx   = depth[IW-1:0];
  assign dec_idx   = dec[IW-1:0];
  assign below_idx = dec2[IW-1:0];
  assign open_ok   = !((nd > MAX_V) || (nt > HALF_V) || ((nd - nt) > HALF_V));

  // Kind of the innermost container once the top level has been removed.
  always_comb begin
    if (dec == '0) begin
      kind_dec = KIND_NONE;
    end else if (amask[below_idx]) begin
      kind_dec = KIND_ARRAY;
    end else if (dmask[below_idx]) begin
      kind_dec = KIND_DICT;
    end else begin
      kind_dec = KIND_STRUCT;
    end
  end

  // Inside a dict entry the key must be basic, the value follows, and then
  // only the closing brace is allowed.
  always_comb begin
    if (kind != KIND_DICT) begin
      dict_ok = 1'b1;
    end else if (prev1 == CH_LBRACE) begin
      dict_ok = is_basic(ch_q);
    end else if (prev2 == CH_LBRACE) begin
      dict_ok = (ch_q != CH_RBRACE);
    end else begin
      dict_ok = (ch_q == CH_RBRACE);
    end
  end

  assign is_open  = (ch_q == CH_LBRACE) || (ch_q == CH_LPAREN) || (ch_q == CH_ARRAY);
  assign is_close = (ch_q == CH_RBRACE) || (ch_q == CH_RPAREN);

  always_comb begin
    if (!mode && stc) begin
      step_ok = 1'b0;
    end else if (!dict_ok) begin
      step_ok = 1'b0;
    end else if (is_open) begin
      step_ok = ((ch_q != CH_LBRACE) || (kind == KIND_ARRAY)) && open_ok;
    end else if (is_close) begin
      step_ok = (kind == ((ch_q == CH_RBRACE) ? KIND_DICT : KIND_STRUCT)) &&
                (prev1 != CH_LPAREN);
    end else begin
      step_ok = (ch_q == CH_VARIANT) || is_basic(ch_q);
    end
  end

  // The result register can take a new beat when empty or being drained.
  // No beat is taken while reset is held.
  assign slot_free = !verdict.valid || verdict.ready;
  assign chr.ready = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode          <= 1'b0;
      depth         <= '0;
      scount        <= '0;
      amask         <= '0;
      dmask         <= '0;
      kind          <= KIND_NONE;
      prev1         <= '0;
      prev2         <= '0;
      ccount        <= '0;
      failed        <= 1'b0;
      stc           <= 1'b0;
      ended         <= 1'b0;
      verdict.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      // A taken beat is dropped unless the next one is loaded in this cycle.
      if (verdict.valid && verdict.ready && (state != S_DONE)) begin
        verdict.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (chr.valid) begin
            ch_q    <= chr.data.ch;
            last_q  <= chr.data.last;
            empty_q <= chr.data.empty_req;
            ended   <= 1'b0;
            state   <= S_STEP;
          end
        end
        S_STEP: begin
          // Length check first; the count advances even when the character
          // is then rejected.
          priority if (empty_q || failed) begin
            state <= S_DONE;
          end else if (ccount == MAX_SIG_LEN) begin
            failed <= 1'b1;
            state  <= S_DONE;
          end else begin
            ccount <= ccount + 8'd1;
            priority if (!step_ok) begin
              failed <= 1'b1;
              state  <= S_DONE;
            end else if (is_open) begin
              depth  <= nd[DW-1:0];
              scount <= nt[SW-1:0];
              if (ch_q == CH_LBRACE) begin
                dmask[top_idx] <= 1'b1;
                kind           <= KIND_DICT;
              end else if (ch_q == CH_ARRAY) begin
                amask[top_idx] <= 1'b1;
                kind           <= KIND_ARRAY;
              end else begin
                kind <= KIND_STRUCT;
              end
              prev2 <= prev1;
              prev1 <= ch_q;
              state <= S_DONE;
            end else if (is_close) begin
              scount         <= scount - SW'(1);
              depth          <= dec;
              dmask[dec_idx] <= 1'b0;
              kind           <= kind_dec;
              state          <= S_POP;
            end else begin
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          // A finished element completes every array that directly holds it.
          if (kind == KIND_ARRAY) begin
            depth          <= dec;
            amask[dec_idx] <= 1'b0;
            kind           <= kind_dec;
          end else begin
            ended <= (kind == KIND_NONE);
            if (kind == KIND_NONE) begin
              stc <= 1'b1;
            end
            prev2 <= prev1;
            prev1 <= ch_q;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            verdict.valid          <= 1'b1;
            verdict.data.done_res  <= last_q;
            verdict.data.valid_res <= last_q && !failed && (kind == KIND_NONE) &&
                                      (depth == '0) && (mode || stc);
            verdict.data.type_end  <= ended;
            if (last_q) begin
              depth  <= '0;
              scount <= '0;
              amask  <= '0;
              dmask  <= '0;
              kind   <= KIND_NONE;
              prev1  <= '0;
              prev2  <= '0;
              ccount <= '0;
              failed <= 1'b0;
              stc    <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Every open level holds either an array or a struct/dict.
  `TSV_ASSERT_SAME(a_depth_covers_structs, 1'b1, {1'b0, depth} >= ({{(DW + 1 - SW){1'b0}}, scount}), "struct count exceeds nesting depth")
  // No array or dict mark may survive above the current depth.
  `TSV_ASSERT_SAME(a_masks_below_depth, 1'b1, ((amask | dmask) >> depth) == '0, "level mark above nesting depth")
  // A passing verdict is only ever given on the final beat of a string.
  `TSV_ASSERT_SAME(a_valid_only_when_done, verdict.valid && verdict.data.valid_res, verdict.data.done_res, "verdict without final beat")
  // After the final beat of a string is emitted, the string state is fresh.
  `TSV_ASSERT_NEXT(a_clear_after_last, (state == S_DONE) && slot_free && last_q, (depth == '0) && !failed && !stc && (ccount == '0), "state not cleared after last beat")

endmodule

// File: sim/type_signature_validator_top_tb.sv
// ---------------------------------------------------------------------------
// type_signature_validator_top_tb
// Drives signature strings one character per beat into the validator and
// checks every verdict beat against a cycle-free model of the nesting rules,
// under random input gaps, output stalls and all settings of the mode register.
// ---------------------------------------------------------------------------
module type_signature_validator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsv_pkg::*;

  localparam int NEST_LIMIT = MAX_NEST_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_CHARS = 40;
  localparam int DRAIN_CYCLES = 60;

  // Register values of mode.
  localparam bit MODE_SINGLE = 1'b0;
  localparam bit MODE_MULTI = 1'b1;

  // Mode used by each random phase, phase 0 in bit 0.
  localparam bit [5:0] PHASE_MODES = 6'b101010;

  localparam string BASIC_CODES = "ybnqiuxthdsog";
  localparam string SHAPE_CODES = "a(){}vs";

  typedef enum logic [1:0] {
    OPEN_NONE,
    OPEN_ARRAY,
    OPEN_STRUCT,
    OPEN_DICT
  } open_kind_e;

  // Tracks the nesting of the string that is in flight and keeps the verdict
  // beats that the accepted characters must produce, oldest first.
  class sig_verdict_board;
    bit mode;
    int level;
    int struct_level;
    int length;
    bit [63:0] array_bits;
    bit [63:0] dict_bits;
    open_kind_e top_kind;
    logic [7:0] last_ch;
    logic [7:0] last_ch2;
    bit broken;
    bit type_closed;
    tsv_out_t verdicts_due[$];
    int errors;

    function new();
      mode = MODE_SINGLE;
      errors = 0;
      clear_string();
    endfunction

    function void clear_string();
      level = 0;
      struct_level = 0;
      length = 0;
      array_bits = '0;
      dict_bits = '0;
      top_kind = OPEN_NONE;
      last_ch = '0;
      last_ch2 = '0;
      broken = 1'b0;
      type_closed = 1'b0;
    endfunction

    function bit basic_code(logic [7:0] c);
      case (c)
        "y", "b", "n", "q", "i", "u", "x", "t", "h", "d", "s", "o", "g": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void settle_kind();
      if (level == 0) top_kind = OPEN_NONE;
      else if (array_bits[level - 1]) top_kind = OPEN_ARRAY;
      else if (dict_bits[level - 1]) top_kind = OPEN_DICT;
      else top_kind = OPEN_STRUCT;
    endfunction

    function bit accept_char(logic [7:0] c, output bit ended);
      int nd;
      int nt;
      ended = 1'b0;
      if (length >= int'(MAX_SIG_LEN)) return 1'b0;
      length++;
      if (!mode && type_closed) return 1'b0;
      // Inside a dict entry: a basic key first, then one value, then the closer.
      if (top_kind == OPEN_DICT) begin
        if (last_ch == CH_LBRACE) begin
          if (!basic_code(c)) return 1'b0;
        end else if (last_ch2 == CH_LBRACE) begin
          if (c == CH_RBRACE) return 1'b0;
        end else if (c != CH_RBRACE) begin
          return 1'b0;
        end
      end
      if (c == CH_LBRACE || c == CH_LPAREN || c == CH_ARRAY) begin
        if (c == CH_LBRACE && top_kind != OPEN_ARRAY) return 1'b0;
        nd = level + 1;
        nt = struct_level + ((c == CH_ARRAY) ? 0 : 1);
        if (nd > NEST_LIMIT || nt > NEST_LIMIT / 2 || nd - nt > NEST_LIMIT / 2) return 1'b0;
        level = nd;
        struct_level = nt;
        if (c == CH_LBRACE) begin
          dict_bits[nd - 1] = 1'b1;
          top_kind = OPEN_DICT;
        end else if (c == CH_ARRAY) begin
          array_bits[nd - 1] = 1'b1;
          top_kind = OPEN_ARRAY;
        end else begin
          top_kind = OPEN_STRUCT;
        end
        last_ch2 = last_ch;
        last_ch = c;
        return 1'b1;
      end
      if (c == CH_RBRACE || c == CH_RPAREN) begin
        if (top_kind != ((c == CH_RBRACE) ? OPEN_DICT : OPEN_STRUCT)) return 1'b0;
        if (last_ch == CH_LPAREN) return 1'b0;
        struct_level--;
        level--;
        dict_bits[level] = 1'b0;
        settle_kind();
      end else if (c != CH_VARIANT && !basic_code(c)) begin
        return 1'b0;
      end
      // A complete element closes every array that was waiting for it.
      while (top_kind == OPEN_ARRAY) begin
        level--;
        array_bits[level] = 1'b0;
        settle_kind();
      end
      if (top_kind == OPEN_NONE) begin
        ended = 1'b1;
        type_closed = 1'b1;
      end
      last_ch2 = last_ch;
      last_ch = c;
      return 1'b1;
    endfunction

    function void note_char(tsv_in_t d);
      tsv_out_t e;
      bit ended;
      ended = 1'b0;
      if (!d.empty_req && !broken) begin
        if (!accept_char(d.ch, ended)) begin
          broken = 1'b1;
          ended = 1'b0;
        end
      end
      e.done_res = d.last;
      e.valid_res = d.last && !broken && top_kind == OPEN_NONE && level == 0 &&
                    (mode || type_closed);
      e.type_end = ended;
      verdicts_due.push_back(e);
      if (d.last) clear_string();
    endfunction

    function void check_verdict(tsv_out_t got);
      tsv_out_t e;
      if (verdicts_due.size() == 0) begin
        $error("verdict beat %b arrived with no character pending", got);
        errors++;
        return;
      end
      e = verdicts_due.pop_front();
      if (got.done_res !== e.done_res) begin
        $error("done_res: expected %0b, actual %0b", e.done_res, got.done_res);
        errors++;
      end
      if (got.valid_res !== e.valid_res) begin
        $error("valid_res: expected %0b, actual %0b", e.valid_res, got.valid_res);
        errors++;
      end
      if (got.type_end !== e.type_end) begin
        $error("type_end: expected %0b, actual %0b", e.type_end, got.type_end);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  tsv_in_if chr_if ();
  tsv_out_if verdict_if ();

  type_signature_validator_top #(
    .MAX_NEST_DEPTH(NEST_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .chr(chr_if),
    .verdict(verdict_if)
  );

  sig_verdict_board sb;
  int chars_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  // Directed strings, sent in single-type mode right after reset. They cover
  // the empty string, a dict inside an array with a variant value, a plain
  // struct, an empty struct, a dict outside an array, a dict whose key is not
  // basic, a dict with no value, a second type after a complete one, an
  // unfinished array, a stray closer and a character that is no type code.
  string single_type_cases[$] = '{"", "a{sv}", "(y)", "()", "{", "a{v", "a{s}",
                                  "ss", "a", ")", "z"};

  // Clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Every verdict beat is compared with the oldest expectation. Values are
  // sampled at the edge, before any of this edge's updates take effect.
  always @(posedge clk) begin
    if (!rst && verdict_if.valid && verdict_if.ready) sb.check_verdict(verdict_if.data);
  end

  // The receiver runs its own stall pattern: stretches of full readiness,
  // light and heavy random stalls and a fixed one-in-four pattern. Once the
  // stimulus is well under way it holds off for a long counted stretch, so
  // that the block backs up and has to refuse characters.
  initial begin
    int style;
    int span;
    int tick;
    bit hold_done;
    hold_done = 1'b0;
    tick = 0;
    verdict_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && chars_sent >= 150) begin
        hold_done = 1'b1;
        verdict_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      style = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        case (style)
          0: verdict_if.ready <= 1'b1;
          1: verdict_if.ready <= ($urandom_range(0, 3) != 0);
          2: verdict_if.ready <= (tick % 4 != 3);
          default: verdict_if.ready <= $urandom_range(0, 1);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  // Offers one beat and returns at the edge where it is taken. The sender
  // works in bursts: when a burst runs out, valid drops for a random gap
  // (sometimes none) before the next burst starts. The expectation is noted
  // here, at the accepting edge, so that it is in place before the stimulus
  // thread can ask whether anything is still outstanding.
  task automatic send_beat(input tsv_in_t d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        chr_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    chr_if.valid <= 1'b1;
    chr_if.data <= d;
    @(posedge clk);
    while (!chr_if.ready) @(posedge clk);
    sb.note_char(d);
    if (!d.empty_req) chars_sent++;
    burst_left--;
  endtask

  // Sends the characters of one string. Now and then an empty beat without
  // last is slipped in, which must change nothing. The string ends either on
  // its final character or on a separate empty beat that carries last; with
  // finish clear, the string is left open.
  task automatic send_string(input logic [7:0] s[$], input bit finish);
    tsv_in_t d;
    bit empty_tail;
    empty_tail = finish && (s.size() == 0 || $urandom_range(0, 5) == 0);
    foreach (s[i]) begin
      if ($urandom_range(0, 15) == 0) begin
        d.ch = 8'($urandom_range(0, 255));
        d.last = 1'b0;
        d.empty_req = 1'b1;
        send_beat(d);
      end
      d.ch = s[i];
      d.last = finish && !empty_tail && (i == s.size() - 1);
      d.empty_req = 1'b0;
      send_beat(d);
    end
    if (empty_tail) begin
      d.ch = 8'($urandom_range(0, 255));
      d.last = 1'b1;
      d.empty_req = 1'b1;
      send_beat(d);
    end
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_string(q, 1'b1);
  endtask

  // Appends one random complete type. Nesting stays shallow here; the deep
  // cases have their own strings.
  task automatic add_type(ref logic [7:0] q[$], input int lvl);
    int r;
    int n;
    r = $urandom_range(0, 9);
    if (lvl >= 4 || r < 4) begin
      if ($urandom_range(0, 7) == 0) q.push_back(CH_VARIANT);
      else q.push_back(BASIC_CODES[$urandom_range(0, BASIC_CODES.len() - 1)]);
    end else if (r < 7) begin
      q.push_back(CH_ARRAY);
      if ($urandom_range(0, 2) == 0) begin
        q.push_back(CH_LBRACE);
        q.push_back(BASIC_CODES[$urandom_range(0, BASIC_CODES.len() - 1)]);
        add_type(q, lvl + 1);
        q.push_back(CH_RBRACE);
      end else begin
        add_type(q, lvl + 1);
      end
    end else begin
      q.push_back(CH_LPAREN);
      n = $urandom_range(1, 3);
      repeat (n) add_type(q, lvl + 1);
      q.push_back(CH_RPAREN);
    end
  endtask

  // Mostly well-formed signatures; a fifth get one character replaced,
  // dropped or inserted, and a tenth are short runs of noise.
  task automatic build_random(ref logic [7:0] q[$], input bit multi);
    int kind;
    int n;
    int pos;
    q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0) q.push_back(8'($urandom_range(0, 255)));
        else q.push_back(SHAPE_CODES[$urandom_range(0, SHAPE_CODES.len() - 1)]);
      end
      return;
    end
    // In single-type mode a second type shows up now and then and must fail.
    n = multi ? $urandom_range(0, 4) : (($urandom_range(0, 7) == 0) ? 2 : 1);
    repeat (n) add_type(q, 0);
    if (kind >= 7 && q.size() != 0) begin
      pos = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 3))
        0: q[pos] = 8'($urandom_range(0, 255));
        1: q[pos] = SHAPE_CODES[$urandom_range(0, SHAPE_CODES.len() - 1)];
        2: q.delete(pos);
        default: q.insert(pos, SHAPE_CODES[$urandom_range(0, SHAPE_CODES.len() - 1)]);
      endcase
    end
  endtask

  // Strings at the nesting and length limits, each just inside and just past
  // the edge: 32 and 33 nested arrays, 32 and 33 nested structs, 32 and 33
  // nested dict entries (64 and 66 levels deep), and 255 and 256 characters.
  task automatic send_extreme(input int which);
    logic [7:0] q[$];
    for (int n = 32; n <= 33; n++) begin
      q.delete();
      case (which)
        0: begin
          repeat (n) q.push_back(CH_ARRAY);
          q.push_back("i");
        end
        1: begin
          repeat (n) q.push_back(CH_LPAREN);
          q.push_back("i");
          repeat (n) q.push_back(CH_RPAREN);
        end
        2: begin
          repeat (n) begin
            q.push_back(CH_ARRAY);
            q.push_back(CH_LBRACE);
            q.push_back("s");
          end
          q.push_back("i");
          repeat (n) q.push_back(CH_RBRACE);
        end
        default: begin
          repeat (n + 223) q.push_back("y");
        end
      endcase
      send_string(q, 1'b1);
    end
  endtask

  // Drops valid and waits until every verdict has come back. Each character
  // yields exactly one verdict, so nothing is left inside the block then.
  task automatic wait_idle();
    chr_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    cfg_wdata <= m;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.mode = m;
  endtask

  initial begin
    logic [7:0] q[$];
    logic [7:0] head[$];
    int split;
    int goal;
    sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    chr_if.valid <= 1'b0;
    chr_if.data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: mode is still at its reset value, single type.
    foreach (single_type_cases[i]) send_text(single_type_cases[i]);
    wait_idle();
    write_mode(MODE_MULTI);
    send_text("");
    send_text("ii");

    // Random phases alternate the mode. The first four each open with one
    // family of limit strings, then every phase sends random signatures until
    // its share of characters is sent. Two phases end with part of a string
    // still open, so that the mode changes in the middle of it and the rest
    // follows in the next phase.
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_mode(PHASE_MODES[p]);
      if (q.size() != 0 || p == 2 || p == 4) send_string(q, 1'b1);
      if (p < 4) send_extreme(p);
      goal = chars_sent + PHASE_CHARS;
      while (chars_sent < goal) begin
        build_random(q, PHASE_MODES[p]);
        send_string(q, 1'b1);
      end
      q.delete();
      if (p == 1 || p == 3) begin
        add_type(q, 0);
        split = $urandom_range(1, q.size());
        head = q[0:split - 1];
        send_string(head, 1'b0);
        q = q[split:$];
      end
    end

    // Let the last verdicts come back, then watch a while for strays.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
